// ===== sv/lstg_pkg.sv =====
package lstg_pkg;

   localparam int GRID_SIZE_DEF = 512;
   localparam int MAX_BEAMS_DEF = 4096;

   localparam int RANGE_W = 16;
   localparam int INDEX_W = 12;
   localparam int PIX_W   = 9;
   localparam int ANG_W   = 16;
   localparam int MAG_W   = 17;   // Q16 sine magnitude, up to 65536
   localparam int QR_W    = 15;   // quarter-turn argument, 0..16384

   localparam logic [16:0] QA      = 17'd102944;
   localparam logic [15:0] QB      = 16'd42048;
   localparam logic [12:0] QC      = 13'd4640;
   localparam logic [14:0] QUARTER = 15'd16384;

   // register indexes
   localparam logic [1:0] REG_START = 2'd0;
   localparam logic [1:0] REG_STEP  = 2'd1;
   localparam logic [1:0] REG_MINR  = 2'd2;
   localparam logic [1:0] REG_MAXR  = 2'd3;

   typedef struct packed {
      logic [15:0] start_angle;
      logic [15:0] angle_step;
      logic [15:0] min_range;
      logic [15:0] range_limit;
   } cfg_type;

endpackage

// ===== sv/lstg_axis.sv =====
// One axis: quarter-wave sine polynomial, scale by range, divide.
// Stages: s1 fold, s2 x2, s3 t1, s4 t2, s5 magnitude, s6 product, then divider steps.
module lstg_axis #(
   parameter int GRID_SIZE = lstg_pkg::GRID_SIZE_DEF,
   parameter int DLAT      = 1
) (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [lstg_pkg::ANG_W-1:0]  angle,
   input  logic [lstg_pkg::RANGE_W-1:0] range_v,
   input  logic [lstg_pkg::RANGE_W-1:0] range_lim,
   output logic                        neg_o,
   output logic [63:0]                 quot_o
);
   localparam int IMGB = $clog2(GRID_SIZE + 1);
   localparam int NUMW = lstg_pkg::RANGE_W + lstg_pkg::MAG_W + IMGB;
   localparam int DENW = lstg_pkg::RANGE_W + 1 + 16;
   localparam int QW   = NUMW;

   logic [14:0] x_ff [4:1];
   logic        ng_ff [DLAT+6:1];
   logic [15:0] rg_ff [5:1];
   logic [15:0] mr_ff [DLAT+5:1];
   logic [14:0] x2_ff;
   logic [14:0] x2b_ff;
   logic [15:0] t1_ff;
   logic [16:0] t2_ff;
   logic [16:0] mag_ff;
   logic [NUMW-1:0] num_ff;

   logic [14:0] x_in;
   logic [1:0]  q;
   logic [29:0] xx;
   logic [27:0] cx;
   logic [31:0] tx;
   logic [31:0] mx;
   logic [15:0] t1_in;
   logic [16:0] t2_in;

   assign q  = angle[15:14];
   assign x_in = q[0] ? (lstg_pkg::QUARTER - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
   assign xx = x_ff[1] * x_ff[1];
   assign cx = lstg_pkg::QC * x2_ff;
   assign t1_in = lstg_pkg::QB - 16'(cx >> 14);
   assign tx = t1_ff * x2b_ff;
   assign t2_in = lstg_pkg::QA - 17'(tx >> 14);
   assign mx = t2_ff * x_ff[4];

   // hold every stage while the output is stalled
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[1]  <= x_in;
         ng_ff[1] <= q[1];
         rg_ff[1] <= range_v;
         mr_ff[1] <= range_lim;
         for (int i = 2; i <= 4; i++) x_ff[i] <= x_ff[i-1];
         for (int i = 2; i <= 5; i++) rg_ff[i] <= rg_ff[i-1];
         for (int i = 2; i <= DLAT+5; i++) mr_ff[i] <= mr_ff[i-1];
         for (int i = 2; i <= DLAT+6; i++) ng_ff[i] <= ng_ff[i-1];
         x2_ff     <= 15'(xx >> 14);
         x2b_ff    <= x2_ff;
         t1_ff     <= t1_in;
         t2_ff     <= t2_in;
         mag_ff    <= 17'(mx >> 14);
         num_ff    <= NUMW'(rg_ff[5]) * NUMW'(mag_ff) * NUMW'(GRID_SIZE);
      end
   end

   // restoring divider, several quotient bits per stage
   logic [NUMW-1:0] rem_ff [DLAT:0];
   logic [QW-1:0]   quo_ff [DLAT:0];
   localparam int BPS = (QW + DLAT - 1) / DLAT;

   always_comb begin
      rem_ff[0] = num_ff;
      quo_ff[0] = '0;
   end

   for (genvar s = 1; s <= DLAT; s++) begin : g_div
      logic [NUMW-1:0] r_in;
      logic [QW-1:0]   q_in;
      logic [DENW-1:0] den;
      assign den = {mr_ff[s+5], 17'd0};
      always_comb begin
         logic [NUMW+DENW:0] trial;
         r_in = rem_ff[s-1];
         q_in = quo_ff[s-1];
         for (int b = 0; b < BPS; b++) begin
            if ((s-1)*BPS + b < QW) begin
               trial = {{(DENW+1){1'b0}}, r_in} -
                       ({{(NUMW+1){1'b0}}, den} << (QW-1-((s-1)*BPS+b)));
               if (!trial[NUMW+DENW]) begin
                  r_in = NUMW'(trial);
                  q_in[QW-1-((s-1)*BPS+b)] = 1'b1;
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s] <= r_in;
            quo_ff[s] <= q_in;
         end
      end
   end

   assign neg_o  = ng_ff[DLAT+6];
   assign quot_o = 64'(quo_ff[DLAT]);
endmodule

// ===== sv/lidar_scan_to_grid_pixel.sv =====
// Channel | Dir | tdata (low bit up)                     | tuser
// req     | in  | range_mm[15:0], beam_index[27:16]      | range_finite
// rsp     | out | pixel_x[8:0], pixel_y[17:9]            | hit
// csr     | in  | register index, 16-bit write value     | -
// One beam enters per cycle while the response is not stalled; the path runs
// through the sine polynomial multipliers and the staged range divider.
// Reset is synchronous and restores the default registers and empties the pipe.
// A stalled response holds the whole pipeline; nothing is lost or repeated.
module lidar_scan_to_grid_pixel #(
   parameter int GRID_SIZE  = lstg_pkg::GRID_SIZE_DEF,
   parameter int MAX_BEAMS  = lstg_pkg::MAX_BEAMS_DEF,
   parameter int DIV_STAGES = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // range_mm[15:0], beam_index[27:16]
   input  logic        req_tuser,   // range_finite
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // pixel_x[8:0], pixel_y[17:9]
   output logic        rsp_tuser,   // hit
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   localparam int LAT  = DIV_STAGES + 7;
   localparam int HALF = GRID_SIZE / 2;

   lstg_pkg::cfg_type cfg_ff;
   logic adv;
   logic [LAT:0] v_ff;
   logic [LAT-1:0] ok_ff;
   logic [15:0] ang_ff;
   logic [15:0] rng_ff;
   logic        ok_in;
   logic [15:0] rng;
   logic [11:0] idx;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{16'd0, 16'd182, 16'd120, 16'd3500};
      end else if (csr_valid) begin
         unique case (csr_index)
            lstg_pkg::REG_START: cfg_ff.start_angle <= csr_data;
            lstg_pkg::REG_STEP:  cfg_ff.angle_step  <= csr_data;
            lstg_pkg::REG_MINR:  cfg_ff.min_range   <= csr_data;
            lstg_pkg::REG_MAXR:  cfg_ff.range_limit <= csr_data;
            default: ;
         endcase
      end
   end

   assign adv = !v_ff[LAT] || rsp_tready;
   assign req_tready = adv;
   assign rng = req_tdata[15:0];
   assign idx = req_tdata[27:16];
   assign ok_in = req_tuser && (cfg_ff.range_limit != 16'd0) &&
                  (32'(idx) < 32'(MAX_BEAMS)) &&
                  (rng >= cfg_ff.min_range) && (rng <= cfg_ff.range_limit);

   // stage 0: form the beam angle
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[LAT-1:0], req_tvalid};
      end
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         ok_ff  <= {ok_ff[LAT-2:0], ok_in};
         ang_ff <= cfg_ff.start_angle + 16'(idx * cfg_ff.angle_step);
         rng_ff <= rng;
      end
   end

   logic nx, ny;
   logic [63:0] qx, qy;
   lstg_axis #(.GRID_SIZE(GRID_SIZE), .DLAT(DIV_STAGES)) u_x (
      .clock, .adv, .angle(ang_ff + 16'd16384), .range_v(rng_ff),
      .range_lim(cfg_ff.range_limit), .neg_o(nx), .quot_o(qx));
   lstg_axis #(.GRID_SIZE(GRID_SIZE), .DLAT(DIV_STAGES)) u_y (
      .clock, .adv, .angle(ang_ff), .range_v(rng_ff),
      .range_lim(cfg_ff.range_limit), .neg_o(ny), .quot_o(qy));

   // centre and bound-check; one output register
   logic [15:0] px, py;
   logic inx, iny;
   assign px = nx ? 16'(HALF) - qx[15:0] : 16'(HALF) + qx[15:0];
   assign py = ny ? 16'(HALF) - qy[15:0] : 16'(HALF) + qy[15:0];
   assign inx = nx ? (qx <= 64'(HALF)) : (qx < 64'(GRID_SIZE - HALF));
   assign iny = ny ? (qy <= 64'(HALF)) : (qy < 64'(GRID_SIZE - HALF));

   logic hit_ff;
   logic [8:0] x_ff, y_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff <= ok_ff[LAT-1] && inx && iny;
         x_ff   <= (ok_ff[LAT-1] && inx && iny) ? px[8:0] : 9'd0;
         y_ff   <= (ok_ff[LAT-1] && inx && iny) ? py[8:0] : 9'd0;
      end
   end

   assign rsp_tvalid = v_ff[LAT];
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = {6'd0, y_ff, x_ff};
endmodule
